>>> rtl/core/mf3_pkg.sv
// Shared types and constants of the 3x3x3 median filter.
// No dependencies; used by scoped name by all but mf3_ram.
package mf3_pkg;

   localparam int VOX_W    = 16;   // voxel width, signed fixed point
   localparam int WIN_N    = 27;   // voxels in one 3x3x3 window
   localparam int COL_N    = 9;    // voxels in one y-z column of the window
   localparam int MED_RANK = 13;   // zero-based rank of the median
   localparam int RANK_W   = 5;    // holds a rank of 0..26
   localparam int CSR_W    = 13;   // widest configuration register
   localparam int EXT_W    = 13;   // width of extents and extent compares
   localparam int ZMAX     = 4096; // largest z extent
   localparam int POS_XY_W = 8;
   localparam int POS_Z_W  = 12;

   typedef enum logic [1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_SIZE_Z = 2'd2
   } csr_index_type;

   typedef logic signed [VOX_W-1:0] voxel_type;

   typedef voxel_type window_type [WIN_N];

   // position and end flag carried beside a voxel through the pipeline
   typedef struct packed {
      logic [POS_XY_W-1:0] pos_x;
      logic [POS_XY_W-1:0] pos_y;
      logic [POS_Z_W-1:0]  pos_z;
      logic                last_out;
   } meta_type;

endpackage

>>> rtl/core/mf3_req_if.sv
// Input channel of the median filter: valid/ready handshake, one voxel a beat.
// Depends on mf3_pkg.
interface mf3_req_if;
   logic               valid;
   logic               ready;
   mf3_pkg::voxel_type voxel;

   modport source (output valid, output voxel, input ready);
   modport sink   (input valid, input voxel, output ready);
endinterface

>>> rtl/core/mf3_rsp_if.sv
// Result channel of the median filter: valid/ready handshake, one median a beat.
// Depends on mf3_pkg.
interface mf3_rsp_if;
   logic                               valid;
   logic                               ready;
   mf3_pkg::voxel_type                 median_value;
   logic [mf3_pkg::POS_XY_W-1:0]       pos_x;
   logic [mf3_pkg::POS_XY_W-1:0]       pos_y;
   logic [mf3_pkg::POS_Z_W-1:0]        pos_z;
   logic                               last_out;

   modport source (output valid, output median_value, output pos_x, output pos_y,
                   output pos_z, output last_out, input ready);
   modport sink   (input valid, input median_value, input pos_x, input pos_y,
                   input pos_z, input last_out, output ready);
endinterface

>>> rtl/core/mf3_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/median_filter_3x3x3.sv
// 3x3x3 median filter over a raster-order volume (x fastest, then y, then z).
// Takes one voxel a cycle and returns one median a cycle for every interior
// voxel while the result channel does not stall; the rate is set by one read
// and one write a cycle on each of two RAMs. Results leave from a register.
// The plane RAM (MAX_X*MAX_Y words of 32 bits) keeps, per (x,y), the voxels of
// the two previous planes; the row RAM (MAX_X words of 96 bits) keeps, per x,
// the 3-deep z columns of the two previous rows. Neither RAM is cleared: after
// reset, or after an extent changes, start a new volume. Depends on mf3_pkg,
// mf3_req_if, mf3_rsp_if and mf3_ram.
module median_filter_3x3x3 #(
   parameter int MAX_X = 256,
   parameter int MAX_Y = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [mf3_pkg::CSR_W-1:0]   csr_wr_data,
   mf3_req_if.sink                     req_ch,
   mf3_rsp_if.source                   rsp_ch
);

   localparam int XW   = $clog2(MAX_X);
   localparam int YW   = $clog2(MAX_Y);
   localparam int A1W  = $clog2(MAX_X * MAX_Y);
   localparam int EW   = mf3_pkg::EXT_W;
   localparam int VW   = mf3_pkg::VOX_W;
   localparam int ZCW  = 3 * VW;   // one 3-deep z column
   localparam int COLW = mf3_pkg::COL_N * VW;
   localparam int WN   = mf3_pkg::WIN_N;

   // configuration
   logic [8:0]  size_x_ff, size_y_ff;
   logic [12:0] size_z_ff;
   logic [EW-1:0] sx, sy, sz, sx_raw, sy_raw, sz_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= 9'd256;
         size_y_ff <= 9'd256;
         size_z_ff <= 13'd256;
      end else if (csr_wr_en) begin
         unique case (mf3_pkg::csr_index_type'(csr_index))
            mf3_pkg::CSR_SIZE_X: size_x_ff <= csr_wr_data[8:0];
            mf3_pkg::CSR_SIZE_Y: size_y_ff <= csr_wr_data[8:0];
            mf3_pkg::CSR_SIZE_Z: size_z_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      sx_raw = EW'(size_x_ff);
      sy_raw = EW'(size_y_ff);
      sz_raw = EW'(size_z_ff);
      sx = (sx_raw < EW'(3)) ? EW'(3) : ((sx_raw > EW'(MAX_X)) ? EW'(MAX_X) : sx_raw);
      sy = (sy_raw < EW'(3)) ? EW'(3) : ((sy_raw > EW'(MAX_Y)) ? EW'(MAX_Y) : sy_raw);
      sz = (sz_raw < EW'(3)) ? EW'(3)
         : ((sz_raw > EW'(mf3_pkg::ZMAX)) ? EW'(mf3_pkg::ZMAX) : sz_raw);
   end

   // pipeline control: each stage moves when the next one is empty or moving
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic adv_out, adv4, adv3, adv2, adv1, accept;

   assign adv_out = !out_valid_ff || rsp_ch.ready;
   assign adv4    = !s4_valid_ff || adv_out;
   assign adv3    = !s3_valid_ff || adv4;
   assign adv2    = !s2_valid_ff || adv3;
   assign adv1    = !s1_valid_ff || adv2;
   assign accept  = req_ch.valid && adv1;
   assign req_ch.ready = adv1;

   // position counters
   logic [XW-1:0] cnt_x_ff, cnt_x_in;
   logic [YW-1:0] cnt_y_ff, cnt_y_in;
   logic [11:0]   cnt_z_ff, cnt_z_in;
   logic [EW-1:0] x_ext, y_ext, z_ext;
   logic          wrap_x, wrap_y, wrap_z, last, interior;
   mf3_pkg::meta_type meta0;

   always_comb begin
      x_ext  = EW'(cnt_x_ff);
      y_ext  = EW'(cnt_y_ff);
      z_ext  = EW'(cnt_z_ff);
      wrap_x = (x_ext + EW'(1)) >= sx;
      wrap_y = (y_ext + EW'(1)) >= sy;
      wrap_z = (z_ext + EW'(1)) >= sz;
      last   = (x_ext == sx - EW'(1)) && (y_ext == sy - EW'(1)) && (z_ext == sz - EW'(1));
      interior = (x_ext >= EW'(2)) && (y_ext >= EW'(2)) && (z_ext >= EW'(2));
      meta0.pos_x    = mf3_pkg::POS_XY_W'(x_ext - EW'(1));
      meta0.pos_y    = mf3_pkg::POS_XY_W'(y_ext - EW'(1));
      meta0.pos_z    = mf3_pkg::POS_Z_W'(z_ext - EW'(1));
      meta0.last_out = last;
      cnt_x_in = cnt_x_ff;
      cnt_y_in = cnt_y_ff;
      cnt_z_in = cnt_z_ff;
      if (wrap_x) begin
         cnt_x_in = '0;
         if (wrap_y) begin
            cnt_y_in = '0;
            cnt_z_in = wrap_z ? '0 : cnt_z_ff + 12'd1;
         end else begin
            cnt_y_in = cnt_y_ff + YW'(1);
         end
      end else begin
         cnt_x_in = cnt_x_ff + XW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_x_ff <= '0;
         cnt_y_ff <= '0;
         cnt_z_ff <= '0;
      end else if (accept) begin
         cnt_x_ff <= cnt_x_in;
         cnt_y_ff <= cnt_y_in;
         cnt_z_ff <= cnt_z_in;
      end
   end

   // stage 1: RAM read data arrives; write the updated history back
   logic [A1W-1:0]      rd_addr1, s1_addr1_ff;
   logic [XW-1:0]       s1_x_ff;
   mf3_pkg::voxel_type  s1_voxel_ff;
   logic                s1_int_ff;
   mf3_pkg::meta_type   s1_meta_ff;
   logic [2*VW-1:0]     plane_rd, plane_wr;
   logic [2*ZCW-1:0]    row_rd, row_wr;
   logic [ZCW-1:0]      new_col;
   logic [COLW-1:0]     col3;
   logic                s1_fire;

   assign rd_addr1 = A1W'(32'(cnt_y_ff) * 32'(MAX_X) + 32'(cnt_x_ff));
   assign s1_fire  = s1_valid_ff && adv1;

   mf3_ram #(.WIDTH(2*VW), .DEPTH(MAX_X*MAX_Y)) u_plane_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr1_ff),
      .wr_data (plane_wr),
      .rd_en   (accept),
      .rd_addr (rd_addr1),
      .rd_data (plane_rd)
   );

   mf3_ram #(.WIDTH(2*ZCW), .DEPTH(MAX_X)) u_row_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_x_ff),
      .wr_data (row_wr),
      .rd_en   (accept),
      .rd_addr (cnt_x_ff),
      .rd_data (row_rd)
   );

   // new z column: this voxel over the two previous planes
   assign new_col  = {s1_voxel_ff, plane_rd};
   assign plane_wr = {s1_voxel_ff, plane_rd[2*VW-1:VW]};
   assign row_wr   = {new_col, row_rd[2*ZCW-1:ZCW]};
   assign col3     = {new_col, row_rd};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_addr1_ff <= rd_addr1;
         s1_x_ff     <= cnt_x_ff;
         s1_voxel_ff <= req_ch.voxel;
         s1_int_ff   <= interior;
         s1_meta_ff  <= meta0;
      end
   end

   // x shift of the two previous 3x3 columns, then window capture
   logic [COLW-1:0]    col_a_ff, col_b_ff;
   logic [WN*VW-1:0]   win_flat;
   mf3_pkg::window_type s2_win_ff;
   mf3_pkg::meta_type   s2_meta_ff;

   assign win_flat = {col_b_ff, col_a_ff, col3};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff && s1_int_ff;
      end
      if (s1_fire) begin
         col_b_ff <= col_a_ff;
         col_a_ff <= col3;
      end
      if (adv2) begin
         for (int k = 0; k < WN; k++) begin
            s2_win_ff[k] <= win_flat[k*VW +: VW];
         end
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // stage 3: pairwise compares, lt[i][j] for i<j means v[j] < v[i]
   logic [WN-1:0]       lt_in [WN];
   logic [WN-1:0]       s3_lt_ff [WN];
   mf3_pkg::window_type s3_win_ff;
   mf3_pkg::meta_type   s3_meta_ff;

   always_comb begin
      for (int i = 0; i < WN; i++) begin
         for (int j = 0; j < WN; j++) begin
            lt_in[i][j] = (j > i) ? (s2_win_ff[j] < s2_win_ff[i]) : 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv3) begin
         s3_lt_ff   <= lt_in;
         s3_win_ff  <= s2_win_ff;
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // stage 4: rank of each voxel, ties broken by window position
   logic [WN-1:0]                 below [WN];
   logic [mf3_pkg::RANK_W-1:0]    rank_in [WN];
   logic [mf3_pkg::RANK_W-1:0]    s4_rank_ff [WN];
   mf3_pkg::window_type           s4_win_ff;
   mf3_pkg::meta_type             s4_meta_ff;

   always_comb begin
      for (int i = 0; i < WN; i++) begin
         for (int j = 0; j < WN; j++) begin
            if (j > i) begin
               below[i][j] = s3_lt_ff[i][j];
            end else if (j < i) begin
               below[i][j] = !s3_lt_ff[j][i];
            end else begin
               below[i][j] = 1'b0;
            end
         end
         rank_in[i] = mf3_pkg::RANK_W'($countones(below[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv4) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv4) begin
         s4_rank_ff <= rank_in;
         s4_win_ff  <= s3_win_ff;
         s4_meta_ff <= s3_meta_ff;
      end
   end

   // output register: pick the voxel of median rank
   mf3_pkg::voxel_type med_in, med_ff;
   mf3_pkg::meta_type  out_meta_ff;

   always_comb begin
      med_in = '0;
      for (int i = 0; i < WN; i++) begin
         if (s4_rank_ff[i] == mf3_pkg::RANK_W'(mf3_pkg::MED_RANK)) begin
            med_in = med_in | s4_win_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv_out) begin
         out_valid_ff <= s4_valid_ff;
      end
      if (adv_out && s4_valid_ff) begin
         med_ff      <= med_in;
         out_meta_ff <= s4_meta_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.median_value = med_ff;
   assign rsp_ch.pos_x        = out_meta_ff.pos_x;
   assign rsp_ch.pos_y        = out_meta_ff.pos_y;
   assign rsp_ch.pos_z        = out_meta_ff.pos_z;
   assign rsp_ch.last_out     = out_meta_ff.last_out;

endmodule

>>> test/median_filter_3x3x3_tb.sv
// Self-checking testbench for median_filter_3x3x3: streams whole volumes, predicts
// each interior median in SystemVerilog and checks every result beat in order.
// Depends on mf3_pkg, mf3_req_if, mf3_rsp_if and the RTL of the block.
module median_filter_3x3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      mf3_pkg::voxel_type           median_value;
      logic [mf3_pkg::POS_XY_W-1:0] pos_x;
      logic [mf3_pkg::POS_XY_W-1:0] pos_y;
      logic [mf3_pkg::POS_Z_W-1:0]  pos_z;
      logic                         last_out;
   } median_beat_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [1:0]                csr_index;
   logic [mf3_pkg::CSR_W-1:0] csr_wr_data;

   mf3_req_if req_ch ();
   mf3_rsp_if rsp_ch ();

   median_filter_3x3x3 u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // mirror of the block: plane store, raster counters, clamped extents
   mf3_pkg::voxel_type plane_mem [3][256][256];
   int                 cnt_x = 0;
   int                 cnt_y = 0;
   int                 cnt_z = 0;
   int                 ext_x = 256;
   int                 ext_y = 256;
   int                 ext_z = 256;
   median_beat_type    expected_medians [$];
   mf3_pkg::voxel_type pending_voxels [$];

   int  errors = 0;
   int  voxels_sent = 0;
   int  medians_checked = 0;
   int  shapes_run = 0;
   bit  no_gaps = 1'b0;
   int  send_gap;
   int  recv_gap;
   bit  hold_armed = 1'b0;
   bit  long_hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #18ms;
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_ext(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // store the voxel, rank the window when it is complete, advance the raster
   function automatic void predict_median(mf3_pkg::voxel_type v);
      mf3_pkg::voxel_type win [mf3_pkg::WIN_N];
      mf3_pkg::voxel_type t;
      median_beat_type    b;
      int                 n, j;
      n = 0;
      plane_mem[cnt_z % 3][cnt_y][cnt_x] = v;
      if (cnt_x >= 2 && cnt_y >= 2 && cnt_z >= 2) begin
         for (int dz = 0; dz < 3; dz++)
            for (int dy = 0; dy < 3; dy++)
               for (int dx = 0; dx < 3; dx++) begin
                  win[n] = plane_mem[(cnt_z - 2 + dz) % 3][cnt_y - 2 + dy][cnt_x - 2 + dx];
                  n++;
               end
         for (int i = 1; i < mf3_pkg::WIN_N; i++) begin
            t = win[i];
            j = i - 1;
            while (j >= 0 && win[j] > t) begin
               win[j + 1] = win[j];
               j--;
            end
            win[j + 1] = t;
         end
         b.median_value = win[mf3_pkg::MED_RANK];
         b.pos_x        = mf3_pkg::POS_XY_W'(cnt_x - 1);
         b.pos_y        = mf3_pkg::POS_XY_W'(cnt_y - 1);
         b.pos_z        = mf3_pkg::POS_Z_W'(cnt_z - 1);
         b.last_out     = (cnt_x == ext_x - 1) && (cnt_y == ext_y - 1) && (cnt_z == ext_z - 1);
         expected_medians.push_back(b);
      end
      if (cnt_x + 1 >= ext_x) begin
         cnt_x = 0;
         if (cnt_y + 1 >= ext_y) begin
            cnt_y = 0;
            cnt_z = (cnt_z + 1 >= ext_z) ? 0 : cnt_z + 1;
         end else begin
            cnt_y++;
         end
      end else begin
         cnt_x++;
      end
   endfunction

   // sender: hold a beat until taken, then gap or offer the next voxel
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.voxel <= '0;
         send_gap     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_median(req_ch.voxel);
         if (req_ch.valid && !req_ch.ready) begin
            // hold
         end else if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_voxels.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.voxel <= pending_voxels.pop_front();
            send_gap     <= pick_gap();
            voxels_sent++;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: compare each beat with the oldest expectation
   always @(posedge clock) begin
      median_beat_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            medians_checked++;
            if (expected_medians.size() == 0) begin
               $error("unexpected median beat at pos %0d,%0d,%0d",
                      rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.pos_z);
               errors++;
            end else begin
               e = expected_medians.pop_front();
               if (rsp_ch.median_value !== e.median_value) begin
                  $error("median_value expected %0d actual %0d", e.median_value,
                         rsp_ch.median_value);
                  errors++;
               end
               if (rsp_ch.pos_x !== e.pos_x) begin
                  $error("pos_x expected %0d actual %0d", e.pos_x, rsp_ch.pos_x);
                  errors++;
               end
               if (rsp_ch.pos_y !== e.pos_y) begin
                  $error("pos_y expected %0d actual %0d", e.pos_y, rsp_ch.pos_y);
                  errors++;
               end
               if (rsp_ch.pos_z !== e.pos_z) begin
                  $error("pos_z expected %0d actual %0d", e.pos_z, rsp_ch.pos_z);
                  errors++;
               end
               if (rsp_ch.last_out !== e.last_out) begin
                  $error("last_out expected %0b actual %0b", e.last_out, rsp_ch.last_out);
                  errors++;
               end
            end
         end
         // one long back-pressure stretch so the block fills and stalls its input
         if (!long_hold_done && hold_armed && rsp_ch.valid) begin
            long_hold_done = 1'b1;
            recv_gap     <= 500;
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap     <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            recv_gap     <= pick_gap();
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic set_extents(int wx, int wy, int wz);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= mf3_pkg::CSR_SIZE_X;
      csr_wr_data <= mf3_pkg::CSR_W'(wx);
      @(posedge clock);
      csr_index   <= mf3_pkg::CSR_SIZE_Y;
      csr_wr_data <= mf3_pkg::CSR_W'(wy);
      @(posedge clock);
      csr_index   <= mf3_pkg::CSR_SIZE_Z;
      csr_wr_data <= mf3_pkg::CSR_W'(wz);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ext_x = clamp_ext(wx & 'h1FF, 3, 256);
      ext_y = clamp_ext(wy & 'h1FF, 3, 256);
      ext_z = clamp_ext(wz & 'h1FFF, 3, mf3_pkg::ZMAX);
      shapes_run++;
   endtask

   // mode 0: full range, 1: narrow range with many ties, 2: extremes, 0 and -1 only
   function automatic mf3_pkg::voxel_type pick_voxel(int mode);
      int r;
      case (mode)
         0: return mf3_pkg::voxel_type'($urandom);
         1: return mf3_pkg::voxel_type'($urandom_range(0, 4) - 2);
         default: begin
            r = $urandom_range(0, 3);
            if (r == 0) return 16'sh8000;
            if (r == 1) return 16'sh7FFF;
            if (r == 2) return 16'sh0000;
            return 16'shFFFF;
         end
      endcase
   endfunction

   function automatic void queue_voxels(int n, int mode);
      for (int i = 0; i < n; i++) pending_voxels.push_back(pick_voxel(mode));
   endfunction

   function automatic int queue_volume(int mode);
      int n;
      n = ext_x * ext_y * ext_z;
      queue_voxels(n, mode);
      return n;
   endfunction

   // drain: every voxel taken, every median back, pipeline settled
   task automatic wait_idle();
      while (pending_voxels.size() > 0 || req_ch.valid || expected_medians.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      no_gaps = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      mf3_pkg::voxel_type directed [27] = '{
         16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
         16'sh5555, 16'shAAAA, 16'sh8000, 16'sh7FFF, 16'sh0000,
         16'sh0000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFE,
         16'sh8001, 16'sh1234, 16'shEDCB, 16'sh0000, 16'sh0001,
         16'shFFFF, 16'sh7FFF, 16'sh8000, 16'sh00FF, 16'shFF00,
         16'sh4000, 16'shC000};
      int random_sent;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = mf3_pkg::CSR_SIZE_X;
      csr_wr_data  = '0;
      random_sent  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // smallest volume with extreme values, then a second one after the wrap
      set_extents(3, 3, 3);
      foreach (directed[i]) pending_voxels.push_back(directed[i]);
      void'(queue_volume(1));
      wait_idle();
      // extents below the floor clamp up to 3
      set_extents(0, 1, 2);
      void'(queue_volume(2));
      wait_idle();
      // long receiver stall on the first median of this volume
      set_extents(10, 6, 5);
      hold_armed = 1'b1;
      void'(queue_volume(0));
      wait_idle();
      // x above the ceiling: rows wrap at 256; shrink x mid-volume and finish
      set_extents(511, 3, 3);
      queue_voxels(300, 0);
      wait_idle();
      set_extents(3, 3, 3);
      queue_voxels(22, 1);
      wait_idle();
      // z above the ceiling, then shrink z mid-volume so plane 5 ends it
      set_extents(3, 3, 13'h1FFF);
      queue_voxels(45, 0);
      wait_idle();
      set_extents(3, 3, 3);
      queue_voxels(9, 2);
      wait_idle();

      while (random_sent < 750) begin
         set_extents($urandom_range(0, 9) == 0 ? $urandom_range(11, 20) : $urandom_range(3, 10),
                     $urandom_range(3, 6), $urandom_range(3, 5));
         repeat ($urandom_range(1, 2))
            random_sent += queue_volume($urandom_range(0, 9) < 6 ? 0 :
                                        $urandom_range(1, 2));
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (expected_medians.size() > 0) begin
         $error("%0d expected medians never arrived", expected_medians.size());
         errors++;
      end
      $display("Sent %0d voxels over %0d extent settings, checked %0d medians.",
               voxels_sent, shapes_run, medians_checked);
      $display("Covered clamped extents, mid-volume resizing and a long output stall.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
